// ===== sv/topk_sparse_sgd_update_defines.svh =====
// assertion macros for the top-k sgd block
`ifndef TOPK_SPARSE_SGD_UPDATE_DEFINES_SVH
`define TOPK_SPARSE_SGD_UPDATE_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define TSU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/tsu_pkg.sv =====
package tsu_pkg;

    localparam int MAX_ELEMS_DEF = 64;
    localparam logic [15:0] LEARN_RATE_RST = 16'd655;
    localparam logic [15:0] KEEP_RATIO_RST = 16'd655;

    localparam logic [1:0] REG_LEARN_RATE = 2'd0;
    localparam logic [1:0] REG_COMPRESS   = 2'd1;
    localparam logic [1:0] REG_KEEP_RATIO = 2'd2;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KCALC,
        ST_SEARCH,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [15:0] learn_rate;
        logic        compress_enable;
        logic [15:0] keep_ratio;
    } cfg_t;

    function automatic logic [32:0] mag33(input logic [31:0] v);
        logic [32:0] s;
        s = {v[31], v};
        return v[31] ? (33'd0 - s) : s;
    endfunction

endpackage

// ===== sv/tsu_cfg.sv =====
module tsu_cfg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tsu_pkg::cfg_t       cfg
);

    logic [15:0] learn_rate_reg;
    logic        compress_reg;
    logic [15:0] keep_ratio_reg;
    logic        wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_rate_reg <= tsu_pkg::LEARN_RATE_RST;
            compress_reg   <= 1'b0;
            keep_ratio_reg <= tsu_pkg::KEEP_RATIO_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                tsu_pkg::REG_LEARN_RATE: learn_rate_reg <= pwdata[15:0];
                tsu_pkg::REG_COMPRESS:   compress_reg   <= pwdata[0];
                tsu_pkg::REG_KEEP_RATIO: keep_ratio_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tsu_pkg::REG_LEARN_RATE: prdata = {16'd0, learn_rate_reg};
            tsu_pkg::REG_COMPRESS:   prdata = {31'd0, compress_reg};
            tsu_pkg::REG_KEEP_RATIO: prdata = {16'd0, keep_ratio_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    assign cfg.learn_rate      = learn_rate_reg;
    assign cfg.compress_enable = compress_reg;
    assign cfg.keep_ratio      = keep_ratio_reg;

endmodule

// ===== sv/tsu_update.sv =====
module tsu_update
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] learn_rate,
    input  logic [31:0] param_in,
    input  logic [31:0] grad_in,
    input  logic        keep_in,
    output logic [31:0] result
);

    logic signed [48:0] prod_reg;
    logic signed [48:0] prod_next;
    logic signed [31:0] param_reg;
    logic signed [33:0] diff;
    logic signed [32:0] q;

    always_comb
    begin
        prod_next = keep_in ? ($signed({1'b0, learn_rate}) * $signed(grad_in)) : 49'sd0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            param_reg <= param_in;
        end
    end

    // arithmetic shift floors toward minus infinity
    assign q    = prod_reg[48:16];
    assign diff = 34'(param_reg) - 34'(q);

    always_comb
    begin
        if (diff > 34'sd2147483647)
            result = 32'h7fffffff;
        else if (diff < -34'sd2147483648)
            result = 32'h80000000;
        else
            result = diff[31:0];
    end

endmodule

// ===== sv/topk_sparse_sgd_update.sv =====
// sequencing: items load at one per cycle while in_ready is high; with compression on,
// the closing item is followed by a k step, 34 counting passes and a marking pass; in
// emit, results pass the read, multiply and output registers, then one per cycle unless stalled
// input is held off from the closing item until the emit pipeline has drained after the
// last result is taken; an output stall freezes the whole emit pipeline
// reset: state and control registers, count and keep mask clear; the stores are left as is
`include "topk_sparse_sgd_update_defines.svh"
module topk_sparse_sgd_update #(
    parameter int MAX_ELEMS = tsu_pkg::MAX_ELEMS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] param_value,
    input  logic [31:0] grad_value,
    input  logic        last_elem,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] new_param,
    output logic        last_out
);

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);

    tsu_pkg::cfg_t  cfg;
    tsu_pkg::state_t state_reg, state_next;

    logic [31:0] param_mem [MAX_ELEMS];
    logic [31:0] grad_mem  [MAX_ELEMS];
    logic [MAX_ELEMS-1:0] keep_reg;

    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] k_reg;
    logic [32:0]   thr_reg;
    logic [5:0]    bit_reg;
    logic [CW-1:0] scan_reg;
    logic          rd_vld_reg;
    logic [AW-1:0] rd_idx_reg;
    logic [CW-1:0] gt_cnt_reg;
    logic [CW-1:0] eq_cnt_reg;
    logic [CW-1:0] eq_seen_reg;
    logic          final_reg;
    logic [31:0]   prd_reg, grd_reg;

    logic          in_acc;
    logic [AW-1:0] wr_idx;
    logic          closing;
    logic [CW+15:0] k_prod;
    logic [32:0]   cand;
    logic [32:0]   rd_mag;
    logic          issue;
    logic [AW-1:0] rd_addr;

    // emit pipeline: read, multiply, output register
    logic          e_v1_reg, e_v2_reg, e_l1_reg, e_l2_reg, e_k1_reg;
    logic          ov_reg, ol_reg;
    logic [31:0]   op_reg, upd;
    logic [CW-1:0] eidx_reg;
    logic          stall;

    tsu_cfg u_cfg (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
    );

    assign in_ready = (state_reg == tsu_pkg::ST_LOAD);
    assign in_acc   = in_valid && in_ready;
    assign wr_idx   = cnt_reg[AW-1:0];
    assign closing  = last_elem || (cnt_reg == CW'(MAX_ELEMS - 1));
    assign k_prod   = (CW+16)'(n_reg) * (CW+16)'(cfg.keep_ratio);
    // the count-greater pass (bit_reg 63) compares against thr + 1
    assign cand     = (bit_reg == 6'd63) ? (thr_reg + 33'd1)
                                         : (thr_reg | (33'd1 << bit_reg));
    assign rd_mag   = tsu_pkg::mag33(grd_reg);
    assign stall    = ov_reg && !out_ready;
    assign issue    = (state_reg == tsu_pkg::ST_EMIT) && !stall && (eidx_reg < n_reg);
    assign rd_addr  = (state_reg == tsu_pkg::ST_EMIT) ? eidx_reg[AW-1:0] : scan_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            param_mem[wr_idx] <= param_value;
            grad_mem[wr_idx]  <= grad_value;
        end
        if (!stall)
        begin
            prd_reg <= param_mem[rd_addr];
            grd_reg <= grad_mem[rd_addr];
        end
    end

    // pass over memory: phase with bit_reg counts elements with mag >= cand;
    // final pass (final_reg) marks elements above threshold or first ties
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tsu_pkg::ST_LOAD:
                if (in_acc && closing)
                    state_next = cfg.compress_enable ? tsu_pkg::ST_KCALC : tsu_pkg::ST_EMIT;
            tsu_pkg::ST_KCALC:
                state_next = tsu_pkg::ST_SEARCH;
            tsu_pkg::ST_SEARCH:
                if (final_reg && scan_reg == n_reg && !rd_vld_reg)
                    state_next = tsu_pkg::ST_EMIT;
            tsu_pkg::ST_EMIT:
                if (eidx_reg == n_reg && !e_v1_reg && !e_v2_reg && !ov_reg)
                    state_next = tsu_pkg::ST_LOAD;
            default:
                state_next = tsu_pkg::ST_LOAD;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tsu_pkg::ST_LOAD;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
            thr_reg     <= '0;
            bit_reg     <= '0;
            scan_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            rd_idx_reg  <= '0;
            gt_cnt_reg  <= '0;
            eq_cnt_reg  <= '0;
            eq_seen_reg <= '0;
            final_reg   <= 1'b0;
            keep_reg    <= '0;
        end
        else
        begin
            case (state_reg)
                tsu_pkg::ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (closing)
                        begin
                            cnt_reg  <= '0;
                            n_reg    <= cnt_reg + CW'(1);
                            keep_reg <= '1;
                        end
                        else
                            cnt_reg <= cnt_reg + CW'(1);
                    end
                end
                tsu_pkg::ST_KCALC:
                begin
                    k_reg       <= (k_prod[CW+15:16] == '0) ? CW'(1) : k_prod[CW+15:16];
                    thr_reg     <= '0;
                    bit_reg     <= 6'd32;
                    scan_reg    <= '0;
                    rd_vld_reg  <= 1'b0;
                    gt_cnt_reg  <= '0;
                    final_reg   <= 1'b0;
                end
                tsu_pkg::ST_SEARCH:
                begin
                    rd_vld_reg <= (scan_reg < n_reg);
                    rd_idx_reg <= scan_reg[AW-1:0];
                    if (scan_reg < n_reg)
                        scan_reg <= scan_reg + CW'(1);
                    if (rd_vld_reg)
                    begin
                        if (!final_reg)
                        begin
                            if (rd_mag >= cand)
                                gt_cnt_reg <= gt_cnt_reg + CW'(1);
                        end
                        else
                        begin
                            if (rd_mag > thr_reg)
                                keep_reg[rd_idx_reg] <= 1'b1;
                            else if (rd_mag == thr_reg && eq_seen_reg < eq_cnt_reg)
                            begin
                                keep_reg[rd_idx_reg] <= 1'b1;
                                eq_seen_reg <= eq_seen_reg + CW'(1);
                            end
                            else
                                keep_reg[rd_idx_reg] <= 1'b0;
                        end
                    end
                    else if (scan_reg == n_reg && !final_reg)
                    begin
                        // end of a pass
                        scan_reg   <= '0;
                        gt_cnt_reg <= '0;
                        if (bit_reg == 6'd63)
                        begin
                            // greater-count pass done: ties fill the rest
                            eq_cnt_reg  <= k_reg - gt_cnt_reg;
                            eq_seen_reg <= '0;
                            final_reg   <= 1'b1;
                        end
                        else
                        begin
                            if (gt_cnt_reg >= k_reg)
                                thr_reg <= cand;
                            if (bit_reg == 6'd0)
                                bit_reg <= 6'd63;
                            else
                                bit_reg <= bit_reg - 6'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    tsu_update u_upd (
        .clk(clk), .en(!stall), .learn_rate(cfg.learn_rate), .param_in(prd_reg),
        .grad_in(grd_reg), .keep_in(e_k1_reg), .result(upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eidx_reg <= '0;
            e_v1_reg <= 1'b0;
            e_v2_reg <= 1'b0;
            e_l1_reg <= 1'b0;
            e_l2_reg <= 1'b0;
            e_k1_reg <= 1'b0;
            ov_reg   <= 1'b0;
            ol_reg   <= 1'b0;
            op_reg   <= '0;
        end
        else if (state_reg != tsu_pkg::ST_EMIT)
        begin
            eidx_reg <= '0;
        end
        else if (!stall)
        begin
            if (issue)
                eidx_reg <= eidx_reg + CW'(1);
            e_v1_reg <= issue;
            e_l1_reg <= (eidx_reg + CW'(1) == n_reg);
            e_k1_reg <= keep_reg[eidx_reg[AW-1:0]];
            e_v2_reg <= e_v1_reg;
            e_l2_reg <= e_l1_reg;
            ov_reg   <= e_v2_reg;
            ol_reg   <= e_l2_reg;
            op_reg   <= upd;
        end
    end

    assign out_valid = ov_reg;
    assign new_param = op_reg;
    assign last_out  = ol_reg;

    `TSU_ASSERT_IMP(a_no_in_busy, state_reg != tsu_pkg::ST_LOAD, !in_ready, "input taken while busy")
    `TSU_ASSERT_IMP(a_out_in_emit, out_valid, state_reg == tsu_pkg::ST_EMIT, "output outside emit")
    `TSU_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(new_param), "output dropped")
    `TSU_ASSERT_IMP(a_k_range, state_reg == tsu_pkg::ST_SEARCH, k_reg != '0 && k_reg <= n_reg, "bad k")

endmodule

// ===== test/tb_top.sv =====
class sgd_scoreboard;
    logic [31:0] exp_param[$];
    logic        exp_last[$];
    logic [31:0] p_mem[64];
    logic [31:0] g_mem[64];
    int          count;
    logic [15:0] lr;
    logic        comp;
    logic [15:0] ratio;
    int          errors;

    function new();
        count = 0;
        lr = 16'd655;
        comp = 1'b0;
        ratio = 16'd655;
        errors = 0;
    endfunction

    function automatic logic [32:0] grad_mag(logic [31:0] v);
        longint s;
        s = longint'(signed'(v));
        if (s < 0)
            s = -s;
        return s[32:0];
    endfunction

    function automatic logic [31:0] apply_update(logic [31:0] p, logic [31:0] g, logic keep);
        longint pv;
        longint gv;
        longint prod;
        longint q;
        longint r;
        pv = longint'(signed'(p));
        gv = keep ? longint'(signed'(g)) : 0;
        prod = longint'(lr) * gv;
        q = prod >>> 16;
        r = pv - q;
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;
        if (r < -64'sd2147483648)
            r = -64'sd2147483648;
        return r[31:0];
    endfunction

    function void note_item(logic [31:0] p, logic [31:0] g, logic last);
        int n;
        int k;
        int rank;
        logic keep;
        p_mem[count] = p;
        g_mem[count] = g;
        n = count + 1;
        if (!last && n < 64)
        begin
            count = n;
            return;
        end
        k = (n * int'(ratio)) >> 16;
        if (k == 0)
            k = 1;
        for (int i = 0; i < n; i++)
        begin
            keep = 1'b1;
            if (comp)
            begin
                rank = 0;
                for (int j = 0; j < n; j++)
                    if (grad_mag(g_mem[j]) > grad_mag(g_mem[i]) ||
                        (grad_mag(g_mem[j]) == grad_mag(g_mem[i]) && j < i))
                        rank++;
                keep = rank < k;
            end
            exp_param = {exp_param, apply_update(p_mem[i], g_mem[i], keep)};
            exp_last = {exp_last, 1'(i == n - 1)};
        end
        count = 0;
    endfunction

    task report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    task check_result(logic [31:0] p, logic l);
        logic [31:0] ep;
        logic el;
        if (exp_param.size() == 0)
        begin
            report("unexpected transaction");
            return;
        end
        ep = exp_param.pop_front();
        el = exp_last.pop_front();
        if (p !== ep)
            report($sformatf("new_param %h exp %h", p, ep));
        if (l !== el)
            report($sformatf("last_out %b exp %b", l, el));
    endtask
endclass

module tb_top;

    localparam logic [1:0] REG_SPARE = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] param_value;
    logic [31:0] grad_value;
    logic        last_elem;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] new_param;
    logic        last_out;

    sgd_scoreboard sb;
    int send_idle;
    int recv_stall;
    int hold_off;
    longint cycles;

    topk_sparse_sgd_update uut (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 3000000)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_item(param_value, grad_value, last_elem);
        if (rst_n && out_valid && out_ready)
            sb.check_result(new_param, last_out);
    end

    // receiver
    initial
    begin
        out_ready = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 0;
                hold_off--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic set_config(logic [15:0] lr, logic c, logic [15:0] r);
        reg_write(tsu_pkg::REG_LEARN_RATE, {16'($urandom), lr});
        reg_write(tsu_pkg::REG_COMPRESS, {31'($urandom), c});
        reg_write(tsu_pkg::REG_KEEP_RATIO, {16'($urandom), r});
        reg_write(REG_SPARE, $urandom);
        sb.lr = lr;
        sb.comp = c;
        sb.ratio = r;
    endtask

    // valid stays high after an accepted transaction until the next one or an idle cycle
    task automatic send_item(logic [31:0] p, logic [31:0] g, logic l);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        param_value <= p;
        grad_value <= g;
        last_elem <= l;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.exp_param.size() != 0)
            @(negedge clk);
        repeat (4 + 64 * 40)
            @(negedge clk);
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_sets(int items);
        int n;
        int left;
        logic [31:0] g;
        left = items;
        while (left > 0)
        begin
            n = ($urandom_range(9) == 0) ? 64 : $urandom_range(1, 10);
            if (n > left)
                n = left;
            g = rand_val();
            for (int i = 0; i < n; i++)
            begin
                if ($urandom_range(3) == 0)
                    g = rand_val();
                send_item(rand_val(), g, (i == n - 1) && (n < 64 || $urandom_range(1)));
            end
            left -= n;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        in_valid = 0;
        param_value = 0;
        grad_value = 0;
        last_elem = 0;
        send_idle = 0;
        recv_stall = 0;
        hold_off = 0;
        repeat (7) @(negedge clk);
        rst_n = 1;

        // directed at reset values
        send_item(32'h7fff_ffff, 32'h8000_0000, 1'b1);
        send_item(32'h8000_0000, 32'h7fff_ffff, 1'b1);
        drain();
        set_config(16'hffff, 1'b1, 16'h8000);
        send_item(32'h7fff_ffff, 32'h8000_0000, 1'b0);
        send_item(32'h1234_5678, 32'h7fff_ffff, 1'b0);
        send_item(32'h8000_0000, 32'h8000_0001, 1'b0);
        send_item(32'h0000_0000, 32'hffff_ffff, 1'b0);
        send_item(32'hffff_ffff, 32'h0000_0001, 1'b0);
        send_item(32'h0001_0000, 32'hffff_ffff, 1'b1);
        drain();
        set_config(16'h0000, 1'b1, 16'h0000);
        send_item(32'hdead_beef, 32'h0000_0005, 1'b0);
        send_item(32'h0bad_cafe, 32'hffff_fffb, 1'b1);
        drain();
        set_config(16'h0001, 1'b1, 16'hffff);
        for (int i = 0; i < 64; i++)
            send_item($urandom, (i % 3 == 0) ? 32'hffff_fff9 : $urandom, 1'b0);
        drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle = (ph == 1 || ph == 3) ? 69 : 0;
            recv_stall = (ph == 2) ? 69 : (ph == 3 ? 16 : 0);
            send_idle = (ph == 3) ? 16 : send_idle;
            set_config(16'($urandom), 1'($urandom_range(1)),
                       (ph == 0) ? 16'h0000 : 16'($urandom));
            if (ph == 2)
                hold_off = 600;
            random_sets(25);
            drain();
            set_config(16'($urandom), 1'b1, 16'($urandom));
            random_sets(25);
            drain();
        end

        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== topk_sparse_sgd_update.f =====
+incdir+sv
sv/tsu_pkg.sv
sv/tsu_cfg.sv
sv/tsu_update.sv
sv/topk_sparse_sgd_update.sv
test/tb_top.sv
